// ===== hw/rtl/mm4_pkg.sv =====
// package: constants and command codes of the 4x4 matrix multiplier
`default_nettype none

package mm4_pkg;

  localparam int unsigned MmDim    = 4;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdW    = 2 * ValueW;

  typedef enum logic [CmdW-1:0] {
    CmdLoadLeft  = 2'd0,
    CmdLoadRight = 2'd1,
    CmdMultiply  = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_multiply_4x4.sv =====
// top level: fixed-point DIM x DIM matrix multiplier on one shared multiply-accumulate unit
//
// usage
//   an item is accepted at a rising edge with start_i high and busy_o low
//   cmd_i load left / load right writes elem_value_i (signed Q16.16) at elem_index_i
//     (row*DIM+column); busy_o stays low, no result beat
//   a load index at or beyond DIM*DIM is dropped; the unused command code does nothing
//   cmd_i multiply raises busy_o and emits DIM*DIM result beats in row-major order,
//     each a single-cycle pulse of result_valid_o with product_value_o, product_index_o
//     and last_element_o (high on the final beat)
//   one 32x32 multiplier and one accumulator compute every dot product, one term per
//     cycle, DIM terms for each result element
//   busy_o drops in the cycle of the last beat, so the next item may follow at once
//   the receiver cannot stall: each beat is valid for exactly one cycle
//   reset clears the sequencer and busy_o; matrix entries are undefined until loaded
`default_nettype none

module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int unsigned DIM = MmDim
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [CmdW-1:0]          cmd_i,
  input  logic [IndexW-1:0]        elem_index_i,
  input  logic signed [ValueW-1:0] elem_value_i,
  output logic                     result_valid_o,
  output logic signed [ValueW-1:0] product_value_o,
  output logic [IndexW-1:0]        product_index_o,
  output logic                     last_element_o
);

  localparam int unsigned NCells = DIM * DIM;
  localparam int unsigned AW     = $clog2(NCells);
  localparam int unsigned DW     = $clog2(DIM);
  localparam int unsigned AccW   = ProdW + $clog2(DIM);
  localparam int unsigned ShW    = AccW - FracBits;
  localparam logic [DW-1:0] DimLast = DW'(DIM - 1);
  localparam logic [AW-1:0] DimA    = AW'(DIM);

  logic accept, load_ok, we_left, we_right;
  logic [AW-1:0] waddr, raddr_left, raddr_right;
  logic [ValueW-1:0] rdata_left, rdata_right;

  assign accept  = start_i && !busy_o;
  assign load_ok = 32'(elem_index_i) < 32'(NCells);
  assign waddr   = AW'(elem_index_i);
  assign we_left  = accept && load_ok && (cmd_i == CmdLoadLeft);
  assign we_right = accept && load_ok && (cmd_i == CmdLoadRight);

  // sequencer
  logic busy_q, busy_d, issue_q, issue_d;
  logic [DW-1:0] row_q, row_d, col_q, col_d, k_q, k_d;
  logic [AW-1:0] pos_q, pos_d;
  logic k_last, el_last;

  // pipeline
  logic s1_valid_q, s1_first_q, s1_lastk_q, s1_lastel_q;
  logic s2_valid_q, s2_first_q, s2_lastk_q, s2_lastel_q;
  logic s3_done_q, s3_lastel_q, out_valid_q;
  logic [AW-1:0] s1_pos_q, s2_pos_q, s3_pos_q;
  logic signed [ValueW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [ShW-1:0] shifted;
  logic [ValueW-1:0] sat_value;
  logic signed [ValueW-1:0] value_q;
  logic [IndexW-1:0] index_q;
  logic last_q;

  assign k_last  = (k_q == DimLast);
  assign el_last = k_last && (col_q == DimLast) && (row_q == DimLast);

  assign raddr_left  = AW'(row_q) * DimA + AW'(k_q);
  assign raddr_right = AW'(k_q) * DimA + AW'(col_q);

  always_comb begin
    busy_d  = busy_q;
    issue_d = issue_q;
    row_d   = row_q;
    col_d   = col_q;
    k_d     = k_q;
    pos_d   = pos_q;
    if (accept && (cmd_i == CmdMultiply)) begin
      busy_d  = 1'b1;
      issue_d = 1'b1;
      row_d   = '0;
      col_d   = '0;
      k_d     = '0;
      pos_d   = '0;
    end else if (issue_q) begin
      if (k_last) begin
        k_d   = '0;
        pos_d = pos_q + AW'(1);
        if (col_q == DimLast) begin
          col_d = '0;
          if (row_q == DimLast) begin
            issue_d = 1'b0;
          end else begin
            row_d = row_q + DW'(1);
          end
        end else begin
          col_d = col_q + DW'(1);
        end
      end else begin
        k_d = k_q + DW'(1);
      end
    end
    if (s3_done_q && s3_lastel_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      issue_q     <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      k_q         <= '0;
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      issue_q     <= issue_d;
      row_q       <= row_d;
      col_q       <= col_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      s1_valid_q  <= issue_q;
      s2_valid_q  <= s1_valid_q;
      s3_done_q   <= s2_valid_q && s2_lastk_q;
      out_valid_q <= s3_done_q;
    end
  end

  mm4_ram #(
    .Width(ValueW),
    .Depth(NCells)
  ) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (we_left),
    .waddr_i(waddr),
    .wdata_i(elem_value_i),
    .raddr_i(raddr_left),
    .rdata_o(rdata_left)
  );

  mm4_ram #(
    .Width(ValueW),
    .Depth(NCells)
  ) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (we_right),
    .waddr_i(waddr),
    .wdata_i(elem_value_i),
    .raddr_i(raddr_right),
    .rdata_o(rdata_right)
  );

  assign mul_a = $signed(rdata_left);
  assign mul_b = $signed(rdata_right);

  // floor shift by dropping fraction bits, then clamp to 32 bits
  assign shifted = acc_q[AccW-1:FracBits];
  always_comb begin
    if ((&shifted[ShW-1:ValueW-1]) || !(|shifted[ShW-1:ValueW-1])) begin
      sat_value = shifted[ValueW-1:0];
    end else if (shifted[ShW-1]) begin
      sat_value = {1'b1, {(ValueW-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(ValueW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q  <= (k_q == '0);
    s1_lastk_q  <= k_last;
    s1_lastel_q <= el_last;
    s1_pos_q    <= pos_q;
    s2_first_q  <= s1_first_q;
    s2_lastk_q  <= s1_lastk_q;
    s2_lastel_q <= s1_lastel_q;
    s2_pos_q    <= s1_pos_q;
    prod_q      <= mul_a * mul_b;
    if (s2_valid_q) begin
      acc_q <= s2_first_q ? AccW'(prod_q) : acc_q + AccW'(prod_q);
    end
    s3_lastel_q <= s2_lastel_q;
    s3_pos_q    <= s2_pos_q;
    value_q     <= $signed(sat_value);
    index_q     <= IndexW'(s3_pos_q);
    last_q      <= s3_lastel_q;
  end

  assign busy_o          = busy_q;
  assign result_valid_o  = out_valid_q;
  assign product_value_o = value_q;
  assign product_index_o = index_q;
  assign last_element_o  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mm4_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module mm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench: fixed-point 4x4 matrix multiplier checked against a cycle-free product predictor
`timescale 1ns / 1ps

module tb_top;
  import mm4_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned Cells       = MmDim * MmDim;
  localparam int unsigned RandomItems = 312;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned TailCycles  = MmDim * MmDim * MmDim + 23;
  localparam int unsigned MaxReports  = 60;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  localparam logic signed [67:0] SatMax = 68'sd2147483647;
  localparam logic signed [67:0] SatMin = -68'sd2147483648;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic [IndexW-1:0]        index;
    logic signed [ValueW-1:0] value;
    logic [6:0]               gap_pct;
    logic                     drain;
  } load_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        index;
    logic                     last;
  } product_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [CmdW-1:0] cmd_i = CmdUnused;
  logic [IndexW-1:0] elem_index_i = '0;
  logic signed [ValueW-1:0] elem_value_i = '0;
  logic busy_o;
  logic result_valid_o;
  logic signed [ValueW-1:0] product_value_o;
  logic [IndexW-1:0] product_index_o;
  logic last_element_o;

  load_item_t item_backlog[$];
  product_t pending_products[$];
  logic signed [ValueW-1:0] left_mat [Cells];
  logic signed [ValueW-1:0] right_mat [Cells];

  logic item_taken = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  matrix_multiply_4x4 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .elem_index_i   (elem_index_i),
    .elem_value_i   (elem_value_i),
    .result_valid_o (result_valid_o),
    .product_value_o(product_value_o),
    .product_index_o(product_index_o),
    .last_element_o (last_element_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  function automatic logic signed [ValueW-1:0] dot_product(input int unsigned row,
                                                           input int unsigned col);
    logic signed [67:0] acc;
    logic signed [67:0] term;
    logic signed [67:0] shifted;
    logic signed [ValueW-1:0] a;
    logic signed [ValueW-1:0] b;
    acc = '0;
    for (int unsigned k = 0; k < MmDim; k++) begin
      a = left_mat[row * MmDim + k];
      b = right_mat[k * MmDim + col];
      term = a * b;
      acc = acc + term;
    end
    shifted = acc >>> FracBits;
    if (shifted > SatMax) return 32'sh7FFF_FFFF;
    if (shifted < SatMin) return 32'sh8000_0000;
    return shifted[ValueW-1:0];
  endfunction

  task automatic predict_products(input logic [CmdW-1:0] cmd, input logic [IndexW-1:0] idx,
                                  input logic signed [ValueW-1:0] val);
    product_t p;
    case (cmd)
      CmdLoadLeft: begin
        left_mat[idx] = val;
      end
      CmdLoadRight: begin
        right_mat[idx] = val;
      end
      CmdMultiply: begin
        for (int unsigned r = 0; r < MmDim; r++) begin
          for (int unsigned c = 0; c < MmDim; c++) begin
            p.value = dot_product(r, c);
            p.index = IndexW'(r * MmDim + c);
            p.last  = (r * MmDim + c == Cells - 1);
            pending_products.push_back(p);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic signed [ValueW-1:0] corner_value(input int unsigned k);
    case (k % 8)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'shFFFF_FFFF;
      3: return 32'sh0000_0000;
      4: return 32'sh0000_0001;
      5: return 32'sh0001_0000;
      6: return 32'shFFFF_0000;
      default: return 32'sh0000_8000;
    endcase
  endfunction

  function automatic logic signed [ValueW-1:0] left_seed(input int unsigned i);
    case (i)
      0: return 32'sh8000_0000;
      1, 2, 3: return 32'sh0000_0000;
      4: return 32'sh0000_0001;
      5: return 32'shFFFF_FFFF;
      6: return 32'sh0001_0000;
      7: return 32'shFFFF_0000;
      8, 9, 10, 11: return 32'sh7FFF_FFFF;
      12: return 32'sh0000_8000;
      13: return 32'shFFFF_8000;
      14: return 32'sh1234_5678;
      default: return 32'shEDCB_A988;
    endcase
  endfunction

  function automatic logic signed [ValueW-1:0] right_seed(input int unsigned i);
    case (i)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0001_0000;
      3: return 32'shFFFF_FFFF;
      4: return 32'sh0000_0003;
      5: return 32'sh0001_0000;
      6: return 32'shFFFF_FFFD;
      7: return 32'sh5555_5555;
      8: return 32'shAAAA_AAAA;
      9: return 32'sh0000_0001;
      10: return 32'sh8000_0000;
      11: return 32'shFFFF_0000;
      12: return 32'sh7FFF_FFFF;
      13: return 32'sh0000_0002;
      14: return 32'sh0000_FFFF;
      default: return 32'sh8000_0001;
    endcase
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned sel;
    logic signed [ValueW-1:0] v;
    sel = $urandom_range(99);
    v = $urandom;
    if (sel < 35) return v;
    if (sel < 70) begin
      v = $urandom_range(32'h0008_0000);
      return v - 32'sh0004_0000;
    end
    if (sel < 85) return corner_value($urandom_range(7));
    return {{16{v[31]}}, v[15:0]};
  endfunction

  function automatic logic [6:0] gap_for(input int unsigned n);
    if (n < RandomItems / 3) return 7'd19;
    if (n < 2 * RandomItems / 3) return 7'd64;
    return 7'd0;
  endfunction

  task automatic add_item(input logic [CmdW-1:0] cmd, input logic [IndexW-1:0] idx,
                          input logic signed [ValueW-1:0] val, input logic [6:0] gap,
                          input logic drain);
    load_item_t it;
    it.cmd     = cmd;
    it.index   = idx;
    it.value   = val;
    it.gap_pct = gap;
    it.drain   = drain;
    item_backlog.push_back(it);
  endtask

  always @(negedge clk_i) begin : driver
    load_item_t nxt;
    if (rst_ni && (!start_i || item_taken)) begin
      if (item_backlog.size() != 0 &&
          !(item_backlog[0].drain && pending_products.size() != 0) &&
          $urandom_range(99) >= item_backlog[0].gap_pct) begin
        nxt = item_backlog.pop_front();
        start_i      <= 1'b1;
        cmd_i        <= nxt.cmd;
        elem_index_i <= nxt.index;
        elem_value_i <= nxt.value;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    product_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_products.size() == 0) begin
          report_mismatch($sformatf("unexpected beat index %0d value %h",
                                    product_index_o, product_value_o));
        end else begin
          want = pending_products.pop_front();
          if (product_value_o !== want.value) begin
            report_mismatch($sformatf("index %0d value got %h want %h",
                                      want.index, product_value_o, want.value));
          end
          if (product_index_o !== want.index) begin
            report_mismatch($sformatf("index got %0d want %0d",
                                      product_index_o, want.index));
          end
          if (last_element_o !== want.last) begin
            report_mismatch($sformatf("index %0d last got %b want %b",
                                      want.index, last_element_o, want.last));
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_products(cmd_i, elem_index_i, elem_value_i);
        item_taken <= 1'b1;
      end else begin
        item_taken <= 1'b0;
      end
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned burst;
    int unsigned tail;
    logic timed_out;
    logic drain;
    logic [6:0] gap;
    counted = 0;
    timed_out = 1'b0;

    // fill both matrices with corner values, then the ignored code and a multiply
    for (int unsigned i = 0; i < Cells; i++) begin
      add_item(CmdLoadLeft, IndexW'(Cells - 1 - i), left_seed(Cells - 1 - i), 7'd19, 1'b0);
      add_item(CmdLoadRight, IndexW'(i), right_seed(i), 7'd19, 1'b0);
    end
    add_item(CmdUnused, 4'hF, 32'shFFFF_FFFF, 7'd19, 1'b0);
    add_item(CmdMultiply, 4'hF, 32'shFFFF_FFFF, 7'd19, 1'b0);

    // load bursts ending in a multiply, with ignored codes sprinkled in
    while (counted < RandomItems) begin
      burst = $urandom_range(0, 14);
      for (int unsigned j = 0; j <= burst; j++) begin
        gap = gap_for(counted);
        drain = (counted == 0 || counted == RandomItems / 3 ||
                 counted == 2 * RandomItems / 3);
        if ($urandom_range(9) == 0) begin
          add_item(CmdUnused, IndexW'($urandom), pick_value(), gap, 1'b0);
        end
        if (j == burst) begin
          add_item(CmdMultiply, IndexW'($urandom), pick_value(), gap, drain);
        end else if ($urandom_range(1) == 0) begin
          add_item(CmdLoadLeft, IndexW'($urandom_range(Cells - 1)), pick_value(), gap, drain);
        end else begin
          add_item(CmdLoadRight, IndexW'($urandom_range(Cells - 1)), pick_value(), gap, drain);
        end
        counted++;
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out &&
           (item_backlog.size() != 0 || start_i || pending_products.size() != 0)) begin
      @(posedge clk_i);
      if (quiet_cycles >= QuietLimit) timed_out = 1'b1;
    end
    tail = 0;
    while (!timed_out && tail < TailCycles) begin
      @(posedge clk_i);
      tail++;
    end
    if (!timed_out && pending_products.size() != 0) begin
      report_mismatch($sformatf("%0d product beats never arrived", pending_products.size()));
    end

    if (!timed_out && mismatch_count == 0) begin
      $display("[matrix_multiply_4x4] OK");
    end else begin
      $display("[matrix_multiply_4x4] ERROR");
    end
    $finish;
  end

endmodule
